// ===== design/lbh_pkg.sv =====
// lbh_pkg: shared types, constants and the mix round for the lookup2 byte hash.
// No dependencies; imported by every module of the block.
package lbh_pkg;

    localparam logic [31:0] GOLDEN_SEED = 32'h9e3779b9;
    localparam int          BLOCK_BYTES = 12;
    localparam int          MIX_STEPS   = 9;
    localparam int          FILL_W      = 4;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } lbh_abc_t;

    // One queued request: an optional full block, an optional key end.
    typedef struct packed {
        logic        start;
        logic        has_block;
        logic        has_final;
        lbh_abc_t    blk;
        lbh_abc_t    fin;
        logic [31:0] seed;
    } lbh_cmd_t;

    function automatic lbh_abc_t mix_step(input logic [3:0] idx, input lbh_abc_t s);
        lbh_abc_t r;
        r = s;
        case (idx)
            4'd0:    r.a = (s.a - s.b - s.c) ^ (s.c >> 13);
            4'd1:    r.b = (s.b - s.c - s.a) ^ (s.a << 8);
            4'd2:    r.c = (s.c - s.a - s.b) ^ (s.b >> 13);
            4'd3:    r.a = (s.a - s.b - s.c) ^ (s.c >> 12);
            4'd4:    r.b = (s.b - s.c - s.a) ^ (s.a << 16);
            4'd5:    r.c = (s.c - s.a - s.b) ^ (s.b >> 5);
            4'd6:    r.a = (s.a - s.b - s.c) ^ (s.c >> 3);
            4'd7:    r.b = (s.b - s.c - s.a) ^ (s.a << 10);
            4'd8:    r.c = (s.c - s.a - s.b) ^ (s.b >> 15);
            default: r = s;
        endcase
        return r;
    endfunction

endpackage

// ===== design/lbh_front.sv =====
// lbh_front: accepts key bytes, gathers 12-byte blocks, builds tail words and
// pushes block / key-end requests into the queue. Depends on lbh_pkg.
module lbh_front
    import lbh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        last,
    input  logic        q_full,
    output logic        push,
    output lbh_cmd_t    cmd
);

    logic [31:0]       init_value_reg;
    logic [31:0]       seed_reg;
    logic              key_open_reg;
    logic              chain_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [31:0]       len_reg;
    logic [7:0]        blk_buf_reg [BLOCK_BYTES];

    logic              accept;
    logic              take;
    logic              blk_done;
    logic [FILL_W-1:0] tail_cnt;
    logic [31:0]       len_next;
    logic [7:0]        eff [BLOCK_BYTES];
    logic [7:0]        tb  [BLOCK_BYTES];

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign take     = accept && byte_present;
    assign blk_done = take && (fill_reg == FILL_W'(BLOCK_BYTES - 1));
    assign tail_cnt = blk_done ? '0 : fill_reg + {{(FILL_W-1){1'b0}}, take};
    assign len_next = len_reg + {31'b0, take};

    always_comb
    begin
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            eff[i] = (take && fill_reg == FILL_W'(i)) ? data_byte : blk_buf_reg[i];
            tb[i]  = (FILL_W'(i) < tail_cnt) ? eff[i] : 8'h00;
        end
    end

    always_comb
    begin
        cmd.start     = !chain_reg;
        cmd.has_block = blk_done;
        cmd.has_final = last;
        cmd.blk.a     = {eff[3], eff[2], eff[1], eff[0]};
        cmd.blk.b     = {eff[7], eff[6], eff[5], eff[4]};
        cmd.blk.c     = {eff[11], eff[10], eff[9], eff[8]};
        cmd.fin.a     = {tb[3], tb[2], tb[1], tb[0]};
        cmd.fin.b     = {tb[7], tb[6], tb[5], tb[4]};
        cmd.fin.c     = {tb[10], tb[9], tb[8], 8'h00} + len_next;
        cmd.seed      = key_open_reg ? seed_reg : init_value_reg;
    end

    assign push = accept && (blk_done || last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_value_reg <= '0;
            key_open_reg   <= 1'b0;
            chain_reg      <= 1'b0;
            fill_reg       <= '0;
            len_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                init_value_reg <= cfg_wdata;
            end
            if (accept)
            begin
                if (last)
                begin
                    key_open_reg <= 1'b0;
                    chain_reg    <= 1'b0;
                    fill_reg     <= '0;
                    len_reg      <= '0;
                end
                else if (take)
                begin
                    key_open_reg <= 1'b1;
                    len_reg      <= len_next;
                    if (blk_done)
                    begin
                        fill_reg  <= '0;
                        chain_reg <= 1'b1;
                    end
                    else
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            blk_buf_reg[fill_reg] <= data_byte;
            if (!key_open_reg)
            begin
                seed_reg <= init_value_reg;
            end
        end
    end

endmodule

// ===== design/lbh_queue.sv =====
// lbh_queue: short FIFO of requests between front and back.
// Depends on lbh_pkg for the request type.
module lbh_queue
    import lbh_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  lbh_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output lbh_cmd_t head,
    output logic     nonempty
);

    localparam int             PTR_W    = $clog2(DEPTH);
    localparam int             CNT_W    = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    lbh_cmd_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_FULL);
    assign nonempty = (count_reg != '0);
    assign head     = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/lbh_back.sv =====
// lbh_back: issues queued requests into a nine-stage mix pipeline, keeps the
// running key state and holds the result register. Depends on lbh_pkg.
module lbh_back
    import lbh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_nonempty,
    input  lbh_cmd_t    head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] hash_value
);

    localparam int L = MIX_STEPS;

    logic        phase_reg;
    logic        busy_reg;
    lbh_abc_t    acc_reg;
    logic        vld_reg [L + 1];
    logic        fin_reg [L + 1];
    lbh_abc_t    abc_reg [L + 1];
    logic        out_valid_reg;
    logic [31:0] out_hash_reg;

    logic        advance;
    logic        blk_phase;
    logic        is_start;
    logic        issue;
    logic        exit_blk;
    logic        load;
    lbh_abc_t    base;
    lbh_abc_t    addend;
    lbh_abc_t    issue_abc;

    assign advance   = !(vld_reg[L] && fin_reg[L] && out_valid_reg && out_stall);
    assign blk_phase = head.has_block && !phase_reg;
    assign is_start  = blk_phase ? head.start : (head.start && !head.has_block);
    assign issue     = q_nonempty && advance && (!busy_reg || (is_start && !blk_phase));
    assign pop       = issue && (!blk_phase || !head.has_final);
    assign exit_blk  = advance && vld_reg[L] && !fin_reg[L];
    assign load      = advance && vld_reg[L] && fin_reg[L];

    always_comb
    begin
        base        = is_start
                    ? lbh_abc_t'{a: GOLDEN_SEED, b: GOLDEN_SEED, c: head.seed}
                    : acc_reg;
        addend      = blk_phase ? head.blk : head.fin;
        issue_abc.a = base.a + addend.a;
        issue_abc.b = base.b + addend.b;
        issue_abc.c = base.c + addend.c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= L; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (pop)
            begin
                phase_reg <= 1'b0;
            end
            else if (issue && blk_phase)
            begin
                phase_reg <= 1'b1;
            end
            if (issue && blk_phase)
            begin
                busy_reg <= 1'b1;
            end
            else if (exit_blk)
            begin
                busy_reg <= 1'b0;
            end
            if (advance)
            begin
                vld_reg[0] <= issue;
                for (int k = 1; k <= L; k++)
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
            out_valid_reg <= load || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fin_reg[0] <= !blk_phase;
            abc_reg[0] <= issue_abc;
            for (int k = 1; k <= L; k++)
            begin
                fin_reg[k] <= fin_reg[k-1];
                abc_reg[k] <= mix_step(4'(k - 1), abc_reg[k-1]);
            end
        end
        if (exit_blk)
        begin
            acc_reg <= abc_reg[L];
        end
        if (load)
        begin
            out_hash_reg <= abc_reg[L].c;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = out_hash_reg;

endmodule

// ===== design/lookup2_byte_hash.sv =====
// lookup2_byte_hash: 32-bit lookup2 hash of a key streamed one byte per request.
// A byte is taken every cycle while the request queue has room; each full 12-byte
// block and each key end run through a nine-stage mix pipeline, and hash_value is
// loaded into the result register from the last stage when the key end leaves it.
// A key end that follows its own block closely waits for that block's mix to leave
// the pipeline; the QUEUE_DEPTH-entry request queue (at least 2) absorbs that wait
// unless short keys arriving meanwhile fill it, which stalls the input. init_value
// seeds the third word and is picked up at the first byte of each key.
module lookup2_byte_hash
    import lbh_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] hash_value
);

    logic     push;
    logic     q_full;
    logic     q_nonempty;
    logic     pop;
    lbh_cmd_t push_cmd;
    lbh_cmd_t head;

    lbh_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .last         (last),
        .q_full       (q_full),
        .push         (push),
        .cmd          (push_cmd)
    );

    lbh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .head     (head),
        .nonempty (q_nonempty)
    );

    lbh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_value (hash_value)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for lookup2_byte_hash, a byte-serial 32-bit lookup2 hash.
// Depends on design/lbh_pkg.sv and design/lookup2_byte_hash.sv; holds its own hash
// predictor, a queue-fed request driver and a result monitor with random stalls.
`timescale 1ns / 1ps

module tb_top;
    import lbh_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       fin;
    } key_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        byte_present = 1'b0;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] hash_value;

    key_req_t    req_backlog[$];
    logic [31:0] hash_expect[$];
    key_req_t    cur_req;

    // predictor state
    logic [31:0] seed_reg;
    lbh_abc_t    acc;
    logic [7:0]  blk[BLOCK_BYTES];
    int          blk_fill;
    logic [31:0] key_len;
    bit          key_started;

    int  send_wait;
    int  recv_wait;
    int  hold_left;
    int  hold_asked;
    int  hold_done;
    bit  send_calm;
    bit  recv_calm;
    int  keyed_reqs;
    int  reqs_accepted;
    int  hashes_checked;
    int  hash_mismatches;
    int  seeds_loaded;

    lookup2_byte_hash DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hash_value   (hash_value)
    );

    always #5 clk = ~clk;

    function automatic lbh_abc_t lookup2_mix(input lbh_abc_t s);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        lbh_abc_t    r;
        a = s.a;
        b = s.b;
        c = s.c;
        a = (a - b - c) ^ (c >> 13);
        b = (b - c - a) ^ (a << 8);
        c = (c - a - b) ^ (b >> 13);
        a = (a - b - c) ^ (c >> 12);
        b = (b - c - a) ^ (a << 16);
        c = (c - a - b) ^ (b >> 5);
        a = (a - b - c) ^ (c >> 3);
        b = (b - c - a) ^ (a << 10);
        c = (c - a - b) ^ (b >> 15);
        r.a = a;
        r.b = b;
        r.c = c;
        return r;
    endfunction

    task automatic new_key();
        acc.a = GOLDEN_SEED;
        acc.b = GOLDEN_SEED;
        acc.c = seed_reg;
        blk_fill = 0;
        key_len = '0;
        key_started = 1'b0;
    endtask

    task automatic hash_absorb(input key_req_t r);
        logic [31:0] v;
        int          i;
        if (r.present)
        begin
            if (!key_started)
            begin
                acc.c = seed_reg;
                key_started = 1'b1;
            end
            blk[blk_fill] = r.data;
            blk_fill++;
            key_len++;
            if (blk_fill == BLOCK_BYTES)
            begin
                acc.a += {blk[3], blk[2], blk[1], blk[0]};
                acc.b += {blk[7], blk[6], blk[5], blk[4]};
                acc.c += {blk[11], blk[10], blk[9], blk[8]};
                acc = lookup2_mix(acc);
                blk_fill = 0;
            end
        end
        if (r.fin)
        begin
            acc.c += key_len;
            // tail bytes 8..10 land one byte higher in the third word
            for (i = 0; i < blk_fill; i++)
            begin
                v = 32'(blk[i]);
                if (i < 4)
                    acc.a += v << (8 * i);
                else if (i < 8)
                    acc.b += v << (8 * (i - 4));
                else
                    acc.c += v << (8 * (i - 7));
            end
            acc = lookup2_mix(acc);
            hash_expect.push_back(acc.c);
            new_key();
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_byte <= '0;
            byte_present <= 1'b0;
            last <= 1'b0;
            send_wait = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                hash_absorb(cur_req);
                reqs_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (req_backlog.size() > 0)
                begin
                    cur_req = req_backlog.pop_front();
                    data_byte <= cur_req.data;
                    byte_present <= cur_req.present;
                    last <= cur_req.fin;
                    in_valid <= 1'b1;
                    send_wait = send_calm ? 0 : $urandom_range(0, 18);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_wait = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (hash_expect.size() == 0)
                begin
                    hash_mismatches++;
                    if (hash_mismatches <= 10)
                        $display("%0t: unexpected hash %h", $time, hash_value);
                end
                else
                begin
                    want = hash_expect.pop_front();
                    if (hash_value !== want)
                    begin
                        hash_mismatches++;
                        if (hash_mismatches <= 10)
                            $display("%0t: hash_value expected %h got %h",
                                     $time, want, hash_value);
                    end
                end
                hashes_checked++;
                recv_wait = recv_calm ? 0 : $urandom_range(0, 18);
            end
            if (hold_done != hold_asked)
            begin
                hold_done = hold_asked;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic push_req(input logic [7:0] d, input logic p, input logic f);
        key_req_t r;
        r.data = d;
        r.present = p;
        r.fin = f;
        req_backlog.push_back(r);
        if (p || f)
            keyed_reqs++;
    endtask

    task automatic queue_key(input int len, input bit split_end);
        int i;
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                push_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            push_req(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !split_end);
        end
        if (split_end || len == 0)
            push_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (req_backlog.size() != 0 || in_valid || hash_expect.size() != 0);
    endtask

    task automatic load_seed(input logic [31:0] v);
        wait_idle();
        repeat (40) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        seed_reg = v;
        if (!key_started)
            acc.c = v;
        seeds_loaded++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] seed_pick[8];
        int          p;
        int          i;
        int          mark;
        int          r;
        seed_reg = '0;
        new_key();
        seed_pick = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                      $urandom, 32'h0000_0000, $urandom, 32'hFFFF_FFFF};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty key, single bytes, split end, ignored request, full block
        push_req(8'h5A, 1'b0, 1'b1);
        push_req(8'hFF, 1'b1, 1'b1);
        push_req(8'h00, 1'b1, 1'b0);
        push_req(8'hFF, 1'b0, 1'b1);
        push_req(8'hA5, 1'b0, 1'b0);
        for (i = 0; i < BLOCK_BYTES; i++)
            push_req((i % 2 == 0) ? 8'hFF : 8'h00, 1'b1, i == BLOCK_BYTES - 1);
        // seed change inside a key applies from the next key on
        for (i = 0; i < 4; i++)
            push_req(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        load_seed(32'hFFFF_FFFF);
        for (i = 0; i < 3; i++)
            push_req(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        push_req(8'h00, 1'b0, 1'b1);

        for (p = 0; p < 8; p++)
        begin
            load_seed(seed_pick[p]);
            send_calm = (p % 3 == 1) || (p == 3);
            recv_calm = (p % 3 == 2);
            mark = keyed_reqs;
            if (p == 3)
            begin
                // receiver holds off while short keys keep coming
                hold_asked++;
                while (keyed_reqs - mark < 50)
                    queue_key($urandom_range(0, 3), 1'($urandom_range(0, 1)));
            end
            else
            begin
                while (keyed_reqs - mark < 30)
                begin
                    r = $urandom_range(0, 9);
                    if (r < 6)
                        queue_key($urandom_range(0, 13), 1'($urandom_range(0, 1)));
                    else if (r < 9)
                        queue_key($urandom_range(12, 30), 1'($urandom_range(0, 1)));
                    else
                        queue_key($urandom_range(31, 50), 1'($urandom_range(0, 1)));
                end
            end
        end

        wait_idle();
        repeat (40) @(posedge clk);
        $display("ran %0d requests (%0d carrying bytes or key ends) over %0d seeds",
                 reqs_accepted, keyed_reqs, seeds_loaded + 1);
        $display("checked %0d hashes, %0d mismatches", hashes_checked, hash_mismatches);
        if (hash_mismatches == 0 && hash_expect.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d hashes outstanding", hash_expect.size());
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
